FILE: rtl/playfair_digraph_encryptor_unit_defines.svh
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_UNIT_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define PDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pde check failed");

// Next-cycle implication, off while reset is asserted
`define PDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pde check failed");

`endif

FILE: rtl/pde_pkg.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - package
// Opcodes, sequencer states, result bundle and square geometry helpers.
// ----------------------------------------------------------------------------
package pde_pkg;

	localparam int CELLS = 25;

	typedef logic [4:0] letter_t;	// 0 = 'a' .. 24 = 'y'
	typedef logic [4:0] cell_t;		// row-major square cell
	typedef logic [2:0] coord_t;	// row or column, 0..4

	localparam letter_t LETTER_X = 5'd23;
	localparam letter_t LETTER_Y = 5'd24;
	localparam cell_t   LAST_CELL = 5'd24;
	localparam coord_t  LAST_COORD = 3'd4;
	localparam logic [7:0] ASCII_A = 8'h61;
	localparam logic [7:0] ASCII_Y = 8'h79;
	localparam logic [7:0] ERR_CHAR = 8'h00;

	typedef enum logic [1:0] {
		OP_KEY       = 2'd0,
		OP_KEY_END   = 2'd1,
		OP_PLAIN     = 2'd2,
		OP_PLAIN_END = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOOK_A,
		ST_LOOK_B,
		ST_CELL0,
		ST_CELL1,
		ST_CAP,
		ST_EMIT0,
		ST_EMIT1,
		ST_ERR
	} state_t;

	// One result offered by the sequencer
	typedef struct packed {
		logic       valid;
		logic [7:0] cipher_char;
		logic       last;
		logic       error;
	} result_t;

	// Write and read request to one 25-entry store
	typedef struct packed {
		logic  we;
		cell_t waddr;
		cell_t wdata;
		cell_t raddr;
	} mem_req_t;

	// Row of a cell: small compare ladder in place of a divide by five
	function automatic coord_t cell_row(input cell_t p);
		coord_t r;
		if (p >= 5'd20)
			r = 3'd4;
		else if (p >= 5'd15)
			r = 3'd3;
		else if (p >= 5'd10)
			r = 3'd2;
		else if (p >= 5'd5)
			r = 3'd1;
		else
			r = 3'd0;
		return r;
	endfunction

	// Row times five, as a cell number
	function automatic cell_t row_base(input coord_t r);
		return {r, 2'b00} + {2'b00, r};
	endfunction

	function automatic coord_t cell_col(input cell_t p);
		cell_t d;
		d = p - row_base(cell_row(p));
		return d[2:0];
	endfunction

endpackage

FILE: rtl/pde_in_if.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - input channel
// Opcode and character byte with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pde_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] char_code;

	modport source (output valid, output opcode, output char_code, input ready);
	modport sink (input valid, input opcode, input char_code, output ready);
endinterface

FILE: rtl/pde_out_if.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - output channel
// Ciphertext letter with last and error flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pde_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] cipher_char;
	logic       last;
	logic       error;

	modport source (output valid, output cipher_char, output last, output error, input ready);
	modport sink (input valid, input cipher_char, input last, input error, output ready);
endinterface

FILE: rtl/pde_cell_unit.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - cell unit
// Given the cell of one letter and the cell of its partner, gives the cell
// of the enciphered letter. Used once per letter of a pair, operands swapped.
// ----------------------------------------------------------------------------
module pde_cell_unit
	import pde_pkg::*;
(
	input  cell_t self_cell,
	input  cell_t other_cell,
	output cell_t out_cell
);

	coord_t rs, cs, ro, co;
	coord_t row, col;

	// Split both cells into row and column
	always_comb begin
		rs = cell_row(self_cell);
		cs = cell_col(self_cell);
		ro = cell_row(other_cell);
		co = cell_col(other_cell);
	end

	// Same row: step right; same column: step down; else take partner column
	always_comb begin
		row = rs;
		col = co;
		if (rs == ro) begin
			col = (cs == LAST_COORD) ? 3'd0 : cs + 3'd1;
		end else if (cs == co) begin
			row = (rs == LAST_COORD) ? 3'd0 : rs + 3'd1;
			col = cs;
		end
	end

	assign out_cell = row_base(row) + {2'b00, col};

endmodule

FILE: rtl/pde_ram.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - 25 x 5 store
// One write port, one read port with registered data. No reset.
// ----------------------------------------------------------------------------
module pde_ram
	import pde_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output cell_t    rdata
);

	cell_t mem [CELLS];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/pde_seq.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - sequencer
// Builds the square, pairs plaintext letters and steps each pair through
// position lookup, the shared cell unit and square reads.
// ----------------------------------------------------------------------------
module pde_seq
	import pde_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_opcode,
	input  logic [7:0] in_char,
	output result_t    res,
	input  logic       res_ready,
	output mem_req_t   place_req,
	input  cell_t      place_rdata,
	output mem_req_t   square_req,
	input  cell_t      square_rdata
);

	state_t state_q, state_d;

	logic [CELLS-1:0] seen_q, seen_eff;
	logic [4:0]       fill_q, fill_eff;
	logic             ready_q;
	letter_t          held_q;
	logic             held_v_q;
	letter_t          walk_q;
	letter_t          a_q, b_q;
	cell_t            pa_q, pb_q;
	letter_t          l0_q, l1_q;

	opcode_t op;
	logic    accept;
	logic    is_letter;
	letter_t idx;
	logic    clr_key;
	letter_t put_letter;
	logic    place_en;
	logic    doubled;
	cell_t   cu_self, cu_other, cu_cell;

	// Decode the incoming item
	always_comb begin
		op        = opcode_t'(in_opcode);
		accept    = in_valid && in_ready;
		is_letter = (in_char >= ASCII_A) && (in_char <= ASCII_Y);
		idx       = 5'(in_char - ASCII_A);
		doubled   = (idx == held_q) && (held_q != LETTER_X);
	end

	// Letter placement: a key byte on accept, or one letter per fill cycle
	always_comb begin
		clr_key    = accept && (op == OP_KEY) && ready_q;
		seen_eff   = clr_key ? '0 : seen_q;
		fill_eff   = clr_key ? 5'd0 : fill_q;
		put_letter = (state_q == ST_FILL) ? walk_q : idx;
		place_en   = ((accept && (op == OP_KEY) && is_letter) || (state_q == ST_FILL))
			&& !seen_eff[put_letter] && (fill_eff < 5'(CELLS));
	end

	// Shared cell unit: first letter, then second with operands swapped
	always_comb begin
		cu_self  = (state_q == ST_CELL0) ? pa_q : pb_q;
		cu_other = (state_q == ST_CELL0) ? place_rdata : pa_q;
	end

	pde_cell_unit u_cell (
		.self_cell  (cu_self),
		.other_cell (cu_other),
		.out_cell   (cu_cell)
	);

	// Store requests
	always_comb begin
		place_req.we     = place_en;
		place_req.waddr  = put_letter;
		place_req.wdata  = fill_eff;
		place_req.raddr  = (state_q == ST_LOOK_A) ? a_q : b_q;
		square_req.we    = place_en;
		square_req.waddr = fill_eff;
		square_req.wdata = put_letter;
		square_req.raddr = cu_cell;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and outputs
	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		res.valid       = 1'b0;
		res.cipher_char = ERR_CHAR;
		res.last        = 1'b0;
		res.error       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (op)
						OP_KEY_END: begin
							if (!ready_q)
								state_d = ST_FILL;
						end
						OP_PLAIN: begin
							if (!ready_q || !is_letter)
								state_d = ST_ERR;
							else if (held_v_q)
								state_d = ST_LOOK_A;
						end
						OP_PLAIN_END: begin
							if (held_v_q)
								state_d = ST_LOOK_A;
						end
						default: ;
					endcase
				end
			end
			ST_FILL: begin
				if (walk_q == LETTER_Y)
					state_d = ST_IDLE;
			end
			ST_LOOK_A: state_d = ST_LOOK_B;
			ST_LOOK_B: state_d = ST_CELL0;
			ST_CELL0:  state_d = ST_CELL1;
			ST_CELL1:  state_d = ST_CAP;
			ST_CAP:    state_d = ST_EMIT0;
			ST_EMIT0: begin
				res.valid       = 1'b1;
				res.cipher_char = ASCII_A + {3'b000, l0_q};
				if (res_ready)
					state_d = ST_EMIT1;
			end
			ST_EMIT1: begin
				res.valid       = 1'b1;
				res.cipher_char = ASCII_A + {3'b000, l1_q};
				res.last        = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			ST_ERR: begin
				res.valid = 1'b1;
				res.last  = 1'b1;
				res.error = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Key state and pending letter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			fill_q   <= 5'd0;
			ready_q  <= 1'b0;
			held_q   <= 5'd0;
			held_v_q <= 1'b0;
		end else begin
			seen_q <= seen_eff | (place_en ? (CELLS'(1) << put_letter) : '0);
			fill_q <= fill_eff + {4'b0000, place_en};
			if (clr_key) begin
				ready_q  <= 1'b0;
				held_v_q <= 1'b0;
			end
			if ((state_q == ST_FILL) && (walk_q == LETTER_Y))
				ready_q <= 1'b1;
			if (accept && (op == OP_PLAIN) && ready_q && is_letter) begin
				if (!held_v_q) begin
					held_q   <= idx;
					held_v_q <= 1'b1;
				end else if (!doubled) begin
					held_v_q <= 1'b0;
				end
			end
			if (accept && (op == OP_PLAIN_END))
				held_v_q <= 1'b0;
		end
	end

	// Pair operands, fill walk and lookup results
	always_ff @(posedge clk) begin
		if (accept && (op == OP_KEY_END))
			walk_q <= 5'd0;
		else if (state_q == ST_FILL)
			walk_q <= walk_q + 5'd1;
		if (accept) begin
			a_q <= held_q;
			b_q <= ((op == OP_PLAIN) && !doubled) ? idx : LETTER_X;
		end
		if (state_q == ST_LOOK_B)
			pa_q <= place_rdata;
		if (state_q == ST_CELL0)
			pb_q <= place_rdata;
		if (state_q == ST_CELL1)
			l0_q <= square_rdata;
		if (state_q == ST_CAP)
			l1_q <= square_rdata;
	end

endmodule

FILE: rtl/playfair_digraph_encryptor_unit.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - top level
// Key bytes build a 5x5 square over 'a'..'y'; plaintext letters are paired
// and each pair gives two ciphertext letters.
//
//  channel  dir  handshake     payload
//  plain    in   valid/ready   opcode[1:0], char_code[7:0]
//  cipher   out  valid/ready   cipher_char[7:0], last, error
//
// A key byte or a first held letter is taken while idle. Key end walks
// the fill state, one letter per cycle through the placement write ports.
// A pair steps through the lookup, cell, capture and emit states, set by
// each store's single read port and the one cell unit, used once per letter.
// Reset clears the key state; the square stores hold no reset value.
// A stalled output holds in its register; the sequencer waits in the emit
// states, with plain.ready low, until the register frees.
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor_unit
	import pde_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pde_in_if.sink    plain,
	pde_out_if.source cipher
);

	result_t  res;
	logic     res_ready;
	mem_req_t place_req, square_req;
	cell_t    place_rdata, square_rdata;

	logic       out_v_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic       out_err_q;

	// Sequencer
	pde_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (plain.valid),
		.in_ready     (plain.ready),
		.in_opcode    (plain.opcode),
		.in_char      (plain.char_code),
		.res          (res),
		.res_ready    (res_ready),
		.place_req    (place_req),
		.place_rdata  (place_rdata),
		.square_req   (square_req),
		.square_rdata (square_rdata)
	);

	// Cell number of each letter
	pde_ram u_place (
		.clk   (clk),
		.req   (place_req),
		.rdata (place_rdata)
	);

	// Letter in each cell
	pde_ram u_square (
		.clk   (clk),
		.req   (square_req),
		.rdata (square_rdata)
	);

	// Output register
	assign res_ready = !out_v_q || cipher.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (res_ready)
			out_v_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_char_q <= res.cipher_char;
			out_last_q <= res.last;
			out_err_q  <= res.error;
		end
	end

	assign cipher.valid       = out_v_q;
	assign cipher.cipher_char = out_char_q;
	assign cipher.last        = out_last_q;
	assign cipher.error       = out_err_q;

endmodule

FILE: rtl/pde_checker.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - port checker
// Watches the output channel of the top level over time.
// ----------------------------------------------------------------------------
`include "playfair_digraph_encryptor_unit_defines.svh"

module pde_checker
	import pde_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] cipher_char,
	input logic       last,
	input logic       error
);

	// A stalled item holds
	`PDE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(cipher_char) && $stable(last) && $stable(error))

	// An error item is a lone zero
	`PDE_ASSERT_NOW(a_err_shape, clk, arst_n, out_valid && error, (cipher_char == ERR_CHAR) && last)

	// Ciphertext stays inside the square alphabet
	`PDE_ASSERT_NOW(a_letter_range, clk, arst_n, out_valid && !error, (cipher_char >= ASCII_A) && (cipher_char <= ASCII_Y))

endmodule

bind playfair_digraph_encryptor_unit pde_checker u_pde_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (cipher.valid),
	.out_ready   (cipher.ready),
	.cipher_char (cipher.cipher_char),
	.last        (cipher.last),
	.error       (cipher.error)
);

FILE: tb/sv/tb_playfair_digraph_encryptor_unit.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor - testbench
// Drives key, key-end, plaintext and plaintext-end items with random gaps on
// both channels. Expected ciphertext comes from an in-bench square model and
// is checked item by item, in order, against what leaves the block.
// ----------------------------------------------------------------------------
module tb_playfair_digraph_encryptor_unit
	import pde_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ITEM_TARGET = 1200;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned SETTLE = 40;
	localparam int unsigned SIDE = 5;

	// What a directed row expects: from the model, one error item, or nothing
	typedef enum logic [1:0] {
		DUE_MODEL,
		DUE_ERROR,
		DUE_NONE
	} due_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       err;
	} cipher_res_t;

	typedef struct {
		opcode_t    op;
		logic [7:0] ch;
		due_kind_t  kind;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	pde_in_if  plain_if ();
	pde_out_if cipher_if ();

	playfair_digraph_encryptor_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.plain  (plain_if),
		.cipher (cipher_if)
	);

	always #1 clk = ~clk;

	// Square model state
	letter_t     grid [CELLS];
	cell_t       letter_cell [CELLS];
	bit          placed [26];
	int unsigned n_filled;
	bit          sq_built;
	letter_t     pend_letter;
	bit          pend_valid;

	cipher_res_t step_out [$];
	cipher_res_t cipher_due [$];

	int unsigned fed_items;
	int unsigned steady_items;
	int unsigned bad_count;
	int unsigned cycle_count;
	bit          hold_req;

	// Directed items: error cases before and after the square, a key with
	// dropped bytes, a repeated key end, doubled letters and an odd tail
	dir_row_t directed [24] = '{
		'{OP_PLAIN,     "a",   DUE_ERROR},
		'{OP_PLAIN_END, 8'h00, DUE_NONE},
		'{OP_KEY,       "p",   DUE_NONE},
		'{OP_KEY,       "l",   DUE_NONE},
		'{OP_KEY,       "a",   DUE_NONE},
		'{OP_KEY,       "y",   DUE_NONE},
		'{OP_KEY,       "z",   DUE_NONE},
		'{OP_KEY,       "p",   DUE_NONE},
		'{OP_KEY,       8'h00, DUE_NONE},
		'{OP_KEY,       8'hff, DUE_NONE},
		'{OP_KEY,       "f",   DUE_NONE},
		'{OP_KEY_END,   8'hff, DUE_NONE},
		'{OP_KEY_END,   8'h00, DUE_NONE},
		'{OP_PLAIN,     "z",   DUE_ERROR},
		'{OP_PLAIN,     8'hff, DUE_ERROR},
		'{OP_PLAIN,     "h",   DUE_MODEL},
		'{OP_PLAIN,     "a",   DUE_MODEL},
		'{OP_PLAIN,     "l",   DUE_MODEL},
		'{OP_PLAIN,     "l",   DUE_MODEL},
		'{OP_PLAIN,     "x",   DUE_MODEL},
		'{OP_PLAIN,     "x",   DUE_MODEL},
		'{OP_PLAIN,     "x",   DUE_MODEL},
		'{OP_PLAIN,     "y",   DUE_MODEL},
		'{OP_PLAIN_END, 8'h00, DUE_MODEL}
	};

	function void clear_key();
		int i;
		for (i = 0; i < 26; i++)
			placed[i] = 1'b0;
		n_filled = 0;
		sq_built = 1'b0;
		pend_valid = 1'b0;
	endfunction

	function void place_letter(input int unsigned idx);
		if (idx > LETTER_Y || placed[idx] || n_filled >= CELLS)
			return;
		placed[idx] = 1'b1;
		grid[n_filled] = letter_t'(idx);
		letter_cell[idx] = cell_t'(n_filled);
		n_filled++;
	endfunction

	// Two ciphertext letters for one pair of plaintext letters
	function void encipher_pair(input letter_t a, input letter_t b);
		int unsigned pa, pb, ra, ca, rb, cb;
		letter_t c0, c1;
		pa = letter_cell[a];
		pb = letter_cell[b];
		ra = pa / SIDE;
		ca = pa % SIDE;
		rb = pb / SIDE;
		cb = pb % SIDE;
		if (ra == rb) begin
			c0 = grid[ra * SIDE + (ca + 1) % SIDE];
			c1 = grid[rb * SIDE + (cb + 1) % SIDE];
		end else if (ca == cb) begin
			c0 = grid[((ra + 1) % SIDE) * SIDE + ca];
			c1 = grid[((rb + 1) % SIDE) * SIDE + cb];
		end else begin
			c0 = grid[ra * SIDE + cb];
			c1 = grid[rb * SIDE + ca];
		end
		step_out.push_back('{ASCII_A + {3'b000, c0}, 1'b0, 1'b0});
		step_out.push_back('{ASCII_A + {3'b000, c1}, 1'b1, 1'b0});
	endfunction

	// Advances the square model by one item; results land in step_out.
	// Returns 0 when the item changes nothing and gives nothing.
	function bit playfair_step(input opcode_t op, input logic [7:0] ch);
		bit is_letter;
		letter_t idx;
		bit took;
		int i;
		step_out.delete();
		is_letter = (ch >= ASCII_A) && (ch <= ASCII_Y);
		idx = is_letter ? letter_t'(ch - ASCII_A) : '0;
		took = 1'b1;
		case (op)
		OP_KEY: begin
			if (sq_built)
				clear_key();
			else if (!is_letter || placed[idx])
				took = 1'b0;
			if (is_letter)
				place_letter(idx);
		end
		OP_KEY_END: begin
			if (sq_built) begin
				took = 1'b0;
			end else begin
				for (i = 0; i <= LETTER_Y; i++)
					place_letter(i);
				sq_built = 1'b1;
			end
		end
		OP_PLAIN: begin
			if (!sq_built || !is_letter) begin
				step_out.push_back('{ERR_CHAR, 1'b1, 1'b1});
			end else if (!pend_valid) begin
				pend_letter = idx;
				pend_valid = 1'b1;
			end else if (idx == pend_letter && pend_letter != LETTER_X) begin
				// doubled letter: pad with x and keep the second one held
				encipher_pair(pend_letter, LETTER_X);
				pend_letter = idx;
			end else begin
				encipher_pair(pend_letter, idx);
				pend_valid = 1'b0;
			end
		end
		default: begin
			if (pend_valid) begin
				encipher_pair(pend_letter, LETTER_X);
				pend_valid = 1'b0;
			end else begin
				took = 1'b0;
			end
		end
		endcase
		return took;
	endfunction

	// Mostly no gap, some short, a few long
	function int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function logic [7:0] rand_letter();
		return ASCII_A + 8'($urandom_range(0, LETTER_Y));
	endfunction

	function logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Presents one item from a falling edge, waits for it to be taken,
	// books the expected results and returns at the next falling edge
	task automatic offer(input opcode_t op, input logic [7:0] ch, input due_kind_t kind);
		int unsigned gap;
		int k;
		if (steady_items != 0) begin
			gap = 0;
			steady_items--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 99) == 0)
				steady_items = $urandom_range(30, 80);
		end
		if (gap != 0) begin
			plain_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		plain_if.valid <= 1'b1;
		plain_if.opcode <= op;
		plain_if.char_code <= ch;
		do
			@(posedge clk);
		while (plain_if.ready !== 1'b1);
		if (playfair_step(op, ch))
			fed_items++;
		case (kind)
		DUE_MODEL: begin
			for (k = 0; k < step_out.size(); k++)
				cipher_due.push_back(step_out[k]);
		end
		DUE_ERROR: cipher_due.push_back('{ERR_CHAR, 1'b1, 1'b1});
		default: ;
		endcase
		@(negedge clk);
	endtask

	// Sender pause: nothing offered until every due item has come out
	task automatic wait_drained();
		plain_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (cipher_due.size() != 0);
	endtask

	// A well-formed message: optional new key and key end, plaintext, optional end
	task automatic send_message();
		int unsigned n, r, k;
		logic [7:0] ch, prev;
		if (!sq_built || $urandom_range(0, 3) != 0) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			for (k = 0; k < n; k++) begin
				ch = ($urandom_range(0, 9) == 0) ? rand_byte() : rand_letter();
				offer(OP_KEY, ch, DUE_MODEL);
			end
			// plaintext while the square is still being keyed
			if ($urandom_range(0, 9) == 0)
				offer(OP_PLAIN, rand_letter(), DUE_MODEL);
			offer(OP_KEY_END, rand_byte(), DUE_MODEL);
		end
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
		prev = rand_letter();
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				ch = prev;
			else if (r < 28)
				ch = ASCII_A + {3'b000, LETTER_X};
			else if (r < 34)
				ch = rand_byte();
			else
				ch = rand_letter();
			offer(OP_PLAIN, ch, DUE_MODEL);
			prev = ch;
		end
		if ($urandom_range(0, 99) < 85)
			offer(OP_PLAIN_END, rand_byte(), DUE_MODEL);
	endtask

	task automatic send_noise();
		int unsigned n, k;
		n = $urandom_range(1, 6);
		for (k = 0; k < n; k++)
			offer(opcode_t'($urandom_range(0, 3)), rand_byte(), DUE_MODEL);
	endtask

	task automatic note_bad(input string what, input cipher_res_t want, input cipher_res_t got);
		bad_count++;
		if (bad_count <= 10)
			$display("%s: expected char %02h last %0b error %0b, got char %02h last %0b error %0b",
				what, want.ch, want.last, want.err, got.ch, got.last, got.err);
	endtask

	// Result checker
	always @(posedge clk) begin : cipher_check
		cipher_res_t got, want;
		if (arst_n === 1'b1 && cipher_if.valid === 1'b1 && cipher_if.ready === 1'b1) begin
			got = '{cipher_if.cipher_char, cipher_if.last, cipher_if.error};
			if (cipher_due.size() == 0) begin
				note_bad("unexpected item", '0, got);
			end else begin
				want = cipher_due.pop_front();
				if (got.ch !== want.ch || got.last !== want.last || got.err !== want.err)
					note_bad("item mismatch", want, got);
			end
		end
	end

	// Receiver: random stalls, ready stretches and one long hold-off
	initial begin : cipher_sink
		int unsigned r, n;
		logic rdy;
		cipher_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 99);
			if (hold_req) begin
				hold_req = 1'b0;
				rdy = 1'b0;
				n = LONG_HOLD;
			end else if (r < 60) begin
				rdy = 1'b1;
				n = $urandom_range(1, 8);
			end else if (r < 90) begin
				rdy = 1'b0;
				n = pick_gap() + 1;
			end else begin
				rdy = 1'b1;
				n = $urandom_range(100, 200);
			end
			cipher_if.ready <= rdy;
			repeat (n - 1) @(negedge clk);
		end
	end

	// Watchdog
	initial begin : watchdog
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		bit hold_done, drain_done;
		int i;
		arst_n = 1'b0;
		plain_if.valid = 1'b0;
		plain_if.opcode = OP_KEY;
		plain_if.char_code = 8'h00;
		hold_req = 1'b0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		fed_items = 0;
		steady_items = 0;
		bad_count = 0;
		for (i = 0; i < CELLS; i++) begin
			grid[i] = '0;
			letter_cell[i] = '0;
		end
		clear_key();
		pend_letter = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[k])
			offer(directed[k].op, directed[k].ch, directed[k].kind);

		// Random part: mostly well-formed messages, some noise
		while (fed_items < ITEM_TARGET) begin
			if ($urandom_range(0, 99) < 85)
				send_message();
			else
				send_noise();
			if (!hold_done && fed_items >= 300) begin
				hold_done = 1'b1;
				hold_req = 1'b1;
			end
			if (!drain_done && fed_items >= 700) begin
				drain_done = 1'b1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (bad_count == 0 && cipher_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
